FILE: design/sac_pkg.sv
// Shared types, widths and constants for the shortest-arc quaternion pipeline.
// No dependencies; every other file uses this package by scoped names.
package sac_pkg;

  localparam int CB     = 16;
  localparam int F      = CB - 1;
  localparam int Q_W    = 31;
  localparam int PROD_W = 2 * Q_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int VAL_W  = 34;
  localparam int MAG_W  = 31;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 64;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int DIVN_W = MAG_W + F + 1;
  localparam int DREM_W = ROOT_W + 1;
  localparam int THR_W  = 31;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(107);
  localparam logic [VAL_W-1:0] ONE_Q30   = VAL_W'(1) << 30;
  localparam logic [F-1:0]     LIM       = {F{1'b1}};

  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  typedef logic signed [CB-1:0]     comp_t;
  typedef logic signed [Q_W-1:0]    q30_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [MAG_W-1:0]         mag_t;

  typedef struct packed {
    comp_t from_x;
    comp_t from_y;
    comp_t from_z;
    comp_t to_x;
    comp_t to_y;
    comp_t to_z;
  } in_word_t;

  typedef struct packed {
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
    comp_t quat_w;
    logic  opposite_case;
  } out_word_t;

  typedef struct packed {
    q30_t fx;
    q30_t fy;
    q30_t fz;
    q30_t tx;
    q30_t ty;
    q30_t tz;
  } s1_t;

  typedef struct packed {
    prod_t xx;
    prod_t yy;
    prod_t zz;
    prod_t yz;
    prod_t zy;
    prod_t zx;
    prod_t xz;
    prod_t xy;
    prod_t yx;
    q30_t  fx;
    q30_t  fy;
    q30_t  fz;
    logic [1:0] sel;
  } s2_t;

  typedef struct packed {
    mag_t [3:0] mag;
    logic [3:0] neg;
    logic       opp;
  } side_t;

  typedef struct packed {
    logic [3:0][SQ_W-1:0] sq;
    logic                 zero;
    side_t                side;
  } s4_t;

  typedef struct packed {
    logic [SUM_W-1:0]  n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              zero;
    side_t             side;
  } root_t;

  typedef struct packed {
    logic [3:0][DREM_W-1:0] rem;
    logic [3:0][F-1:0]      lo;
    logic [3:0][F-1:0]      quo;
    logic [3:0]             sat;
    logic [ROOT_W-1:0]      norm;
    logic [3:0]             neg;
    logic                   zero;
    logic                   opp;
  } div_t;

  function automatic q30_t to_q30(comp_t v);
    logic signed [Q_W+CB-1:0] w;
    w = {{Q_W{v[CB-1]}}, v};
    if (F <= 30) begin
      w = w <<< (30 - F);
    end else begin
      w = w >>> (F - 30);
    end
    return w[Q_W-1:0];
  endfunction

endpackage

FILE: design/shortest_arc_quaternion.sv
// Throughput: one word per cycle while out_ready is high; the square root
// (one bit per stage) and the division (one quotient bit per stage) are
// fully pipelined. Reset (synchronous, rst_n low) empties the pipeline and
// loads the opposite threshold with 107.
module shortest_arc_quaternion (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [sac_pkg::THR_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sac_pkg::in_word_t          in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sac_pkg::out_word_t         out_word
);

  logic [sac_pkg::THR_W-1:0] thr_r;
  logic p_valid, p_ready, m_valid, m_ready, s_valid, s_ready;
  sac_pkg::s2_t   p_s2;
  sac_pkg::root_t m_root, s_root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= sac_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  sac_prod u_prod (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_word,
    .out_valid(p_valid), .out_ready(p_ready), .out_s2(p_s2)
  );

  sac_mix u_mix (
    .clk, .rst_n, .thr(thr_r),
    .in_valid(p_valid), .in_ready(p_ready), .in_s2(p_s2),
    .out_valid(m_valid), .out_ready(m_ready), .out_root(m_root)
  );

  sac_sqrt u_sqrt (
    .clk, .rst_n,
    .in_valid(m_valid), .in_ready(m_ready), .in_root(m_root),
    .out_valid(s_valid), .out_ready(s_ready), .out_root(s_root)
  );

  sac_div u_div (
    .clk, .rst_n,
    .in_valid(s_valid), .in_ready(s_ready), .in_root(s_root),
    .out_valid, .out_ready, .out_word
  );

  a_opp_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.opposite_case |-> out_word.quat_w == '0)
    else $error("opposite result with nonzero w");

  a_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.opposite_case |-> !out_word.quat_w[sac_pkg::CB-1])
    else $error("negative w on the normal path");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.quat_x != {1'b1, {(sac_pkg::CB-1){1'b0}}}
               && out_word.quat_y != {1'b1, {(sac_pkg::CB-1){1'b0}}})
    else $error("saturation let the most negative code through");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

FILE: design/sac_prod.sv
// Front stages: scale to Q.30, nine from/to products, smallest-axis pick.
// Depends on sac_pkg.
module sac_prod (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sac_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output sac_pkg::s2_t      out_s2
);

  localparam int Q_W_MAG = sac_pkg::Q_W + 1;

  sac_pkg::s1_t s1_r, s1_nxt;
  sac_pkg::s2_t s2_r, s2_nxt;
  logic v1_r, v2_r;
  logic rdy1, rdy2;
  logic [Q_W_MAG-1:0] ax, ay, az;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s1_nxt.fx = sac_pkg::to_q30(in_word.from_x);
    s1_nxt.fy = sac_pkg::to_q30(in_word.from_y);
    s1_nxt.fz = sac_pkg::to_q30(in_word.from_z);
    s1_nxt.tx = sac_pkg::to_q30(in_word.to_x);
    s1_nxt.ty = sac_pkg::to_q30(in_word.to_y);
    s1_nxt.tz = sac_pkg::to_q30(in_word.to_z);
  end

  always_comb begin
    ax = s1_r.fx[sac_pkg::Q_W-1] ? Q_W_MAG'(-Q_W_MAG'(s1_r.fx)) : Q_W_MAG'(s1_r.fx);
    ay = s1_r.fy[sac_pkg::Q_W-1] ? Q_W_MAG'(-Q_W_MAG'(s1_r.fy)) : Q_W_MAG'(s1_r.fy);
    az = s1_r.fz[sac_pkg::Q_W-1] ? Q_W_MAG'(-Q_W_MAG'(s1_r.fz)) : Q_W_MAG'(s1_r.fz);
    s2_nxt.xx = s1_r.fx * s1_r.tx;
    s2_nxt.yy = s1_r.fy * s1_r.ty;
    s2_nxt.zz = s1_r.fz * s1_r.tz;
    s2_nxt.yz = s1_r.fy * s1_r.tz;
    s2_nxt.zy = s1_r.fz * s1_r.ty;
    s2_nxt.zx = s1_r.fz * s1_r.tx;
    s2_nxt.xz = s1_r.fx * s1_r.tz;
    s2_nxt.xy = s1_r.fx * s1_r.ty;
    s2_nxt.yx = s1_r.fy * s1_r.tx;
    s2_nxt.fx = s1_r.fx;
    s2_nxt.fy = s1_r.fy;
    s2_nxt.fz = s1_r.fz;
    if (ax <= ay && ax <= az) begin
      s2_nxt.sel = sac_pkg::SEL_X;
    end else if (ay <= az) begin
      s2_nxt.sel = sac_pkg::SEL_Y;
    end else begin
      s2_nxt.sel = sac_pkg::SEL_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r) s2_r <= s2_nxt;
  end

  assign out_valid = v2_r;
  assign out_s2    = s2_r;

endmodule

FILE: design/sac_mix.sv
// Middle stages: dot/cross or perpendicular axis, magnitudes, squares, sum.
// Depends on sac_pkg.
module sac_mix (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [sac_pkg::THR_W-1:0]        thr,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sac_pkg::s2_t                     in_s2,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sac_pkg::root_t                   out_root
);

  localparam int VW = sac_pkg::VAL_W;

  sac_pkg::side_t s3_r, s3_nxt;
  sac_pkg::s4_t   s4_r, s4_nxt;
  sac_pkg::root_t s5_r, s5_nxt;
  logic v3_r, v4_r, v5_r;
  logic rdy3, rdy4, rdy5;

  logic signed [sac_pkg::ACC_W-1:0] dot_acc, cx_acc, cy_acc, cz_acc;
  logic signed [sac_pkg::ACC_W-1:0] dot_sh, cx_sh, cy_sh, cz_sh;
  logic signed [VW-1:0] w_val, fx_v, fy_v, fz_v, q28;
  logic signed [VW-1:0] qv [4];
  logic [VW-1:0] mag_full;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign in_ready = rdy3;

  always_comb begin
    dot_acc = sac_pkg::ACC_W'(in_s2.xx) + sac_pkg::ACC_W'(in_s2.yy)
            + sac_pkg::ACC_W'(in_s2.zz);
    cx_acc  = sac_pkg::ACC_W'(in_s2.yz) - sac_pkg::ACC_W'(in_s2.zy);
    cy_acc  = sac_pkg::ACC_W'(in_s2.zx) - sac_pkg::ACC_W'(in_s2.xz);
    cz_acc  = sac_pkg::ACC_W'(in_s2.xy) - sac_pkg::ACC_W'(in_s2.yx);
    dot_sh  = dot_acc >>> 30;
    cx_sh   = cx_acc >>> 30;
    cy_sh   = cy_acc >>> 30;
    cz_sh   = cz_acc >>> 30;
    w_val   = dot_sh[VW-1:0] + sac_pkg::ONE_Q30;
    fx_v    = VW'(in_s2.fx);
    fy_v    = VW'(in_s2.fy);
    fz_v    = VW'(in_s2.fz);
    s3_nxt.opp = w_val < $signed({{(VW-sac_pkg::THR_W){1'b0}}, thr});
    if (s3_nxt.opp) begin
      qv[3] = '0;
      case (in_s2.sel)
        sac_pkg::SEL_X: begin
          qv[0] = '0;     qv[1] = -fz_v; qv[2] = fy_v;
        end
        sac_pkg::SEL_Y: begin
          qv[0] = -fz_v;  qv[1] = '0;    qv[2] = fx_v;
        end
        default: begin
          qv[0] = -fy_v;  qv[1] = fx_v;  qv[2] = '0;
        end
      endcase
    end else begin
      qv[0] = cx_sh[VW-1:0];
      qv[1] = cy_sh[VW-1:0];
      qv[2] = cz_sh[VW-1:0];
      qv[3] = w_val;
    end
    for (int i = 0; i < 4; i++) begin
      q28 = qv[i] >>> 2;
      s3_nxt.neg[i] = q28[VW-1];
      mag_full = q28[VW-1] ? VW'(-q28) : VW'(q28);
      s3_nxt.mag[i] = mag_full[sac_pkg::MAG_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s4_nxt.sq[i] = s3_r.mag[i] * s3_r.mag[i];
    end
    s4_nxt.zero = (s3_r.mag == '0);
    s4_nxt.side = s3_r;
  end

  always_comb begin
    s5_nxt.n    = sac_pkg::SUM_W'(s4_r.sq[0]) + sac_pkg::SUM_W'(s4_r.sq[1])
                + sac_pkg::SUM_W'(s4_r.sq[2]) + sac_pkg::SUM_W'(s4_r.sq[3]);
    s5_nxt.rem  = '0;
    s5_nxt.root = '0;
    s5_nxt.zero = s4_r.zero;
    s5_nxt.side = s4_r.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= in_valid;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) s3_r <= s3_nxt;
    if (rdy4 && v3_r) s4_r <= s4_nxt;
    if (rdy5 && v4_r) s5_r <= s5_nxt;
  end

  assign out_valid = v5_r;
  assign out_root  = s5_r;

endmodule

FILE: design/sac_sqrt.sv
// Integer square root of the sum of squares, one result bit per stage.
// Depends on sac_pkg.
module sac_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sac_pkg::root_t in_root,
  output logic           out_valid,
  input  logic           out_ready,
  output sac_pkg::root_t out_root
);

  localparam int NS = sac_pkg::ROOT_W;
  localparam int RW = sac_pkg::REM_W;

  sac_pkg::root_t st_r [NS];
  sac_pkg::root_t src [NS];
  logic [NS-1:0] v_r;
  logic [NS-1:0] src_v;
  logic [NS:0]   rdy;

  function automatic sac_pkg::root_t step(sac_pkg::root_t s);
    sac_pkg::root_t o;
    logic [RW-1:0] rem_sh, trial;
    o      = s;
    rem_sh = {s.rem[RW-3:0], s.n[sac_pkg::SUM_W-1 -: 2]};
    trial  = RW'({s.root, 2'b01});
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[sac_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[sac_pkg::ROOT_W-2:0], 1'b0};
    end
    o.n = s.n << 2;
    return o;
  endfunction

  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src[k]   = in_root;
      assign src_v[k] = in_valid;
    end else begin : g_next
      assign src[k]   = st_r[k-1];
      assign src_v[k] = v_r[k-1];
    end
    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v[k]) st_r[k] <= step(src[k]);
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = st_r[NS-1];

endmodule

FILE: design/sac_div.sv
// Per-lane rounded division by the norm, saturation, sign and output register.
// Depends on sac_pkg.
module sac_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sac_pkg::root_t     in_root,
  output logic               out_valid,
  input  logic               out_ready,
  output sac_pkg::out_word_t out_word
);

  localparam int F  = sac_pkg::F;
  localparam int DW = sac_pkg::DREM_W;
  localparam int NW = sac_pkg::DIVN_W;
  localparam int NS = F + 3;

  sac_pkg::div_t     set_r, set_nxt;
  sac_pkg::div_t     sat_r, sat_nxt;
  sac_pkg::div_t     stp_r [F];
  sac_pkg::div_t     stp_src [F];
  sac_pkg::out_word_t out_r, out_nxt;
  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [NW-1:0] num;
  logic [sac_pkg::CB-1:0] res [4];

  function automatic sac_pkg::div_t step(sac_pkg::div_t s);
    sac_pkg::div_t o;
    logic [DW-1:0] rs;
    o = s;
    for (int i = 0; i < 4; i++) begin
      rs = {s.rem[i][DW-2:0], s.lo[i][F-1]};
      if (rs >= DW'(s.norm)) begin
        o.rem[i] = rs - DW'(s.norm);
        o.quo[i] = {s.quo[i][F-2:0], 1'b1};
      end else begin
        o.rem[i] = rs;
        o.quo[i] = {s.quo[i][F-2:0], 1'b0};
      end
      o.lo[i] = s.lo[i] << 1;
    end
    return o;
  endfunction

  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  always_comb begin
    set_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      num = NW'({in_root.side.mag[i], {F{1'b0}}}) + NW'(in_root.root >> 1);
      set_nxt.rem[i] = DW'(num >> F);
      set_nxt.lo[i]  = num[F-1:0];
    end
    set_nxt.norm = in_root.root;
    set_nxt.neg  = in_root.side.neg;
    set_nxt.zero = in_root.zero;
    set_nxt.opp  = in_root.side.opp;
  end

  always_comb begin
    sat_nxt = set_r;
    for (int i = 0; i < 4; i++) begin
      sat_nxt.sat[i] = set_r.rem[i] >= DW'(set_r.norm);
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_step
    if (k == 0) begin : g_first
      assign stp_src[k] = sat_r;
    end else begin : g_next
      assign stp_src[k] = stp_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (rdy[k+2] && v_r[k+1]) stp_r[k] <= step(stp_src[k]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res[i] = {1'b0, stp_r[F-1].sat[i] ? sac_pkg::LIM : stp_r[F-1].quo[i]};
      if (stp_r[F-1].neg[i]) res[i] = -res[i];
      if (stp_r[F-1].zero) res[i] = '0;
    end
    out_nxt.quat_x        = res[0];
    out_nxt.quat_y        = res[1];
    out_nxt.quat_z        = res[2];
    out_nxt.quat_w        = res[3];
    out_nxt.opposite_case = stp_r[F-1].opp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) set_r <= set_nxt;
    if (rdy[1] && v_r[0]) sat_r <= sat_nxt;
    if (rdy[NS-1] && v_r[NS-2]) out_r <= out_nxt;
  end

  assign out_valid = v_r[NS-1];
  assign out_word  = out_r;

endmodule
